// File: rtl/sed_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// String escape decoder package
// Shared types, character codes and helper functions for the decoder.
// ----------------------------------------------------------------------------
package sed_pkg;

    localparam int MAX_DECODED_BYTES = 4095;
    localparam int DECODED_W         = 12;
    localparam int SAT_W             = $clog2(MAX_DECODED_BYTES + 1);
    localparam int CNT_W             = (SAT_W > DECODED_W) ? SAT_W : DECODED_W;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X         = 8'h78;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_NINE      = 8'h39;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_A         = 8'h61;
    localparam logic [7:0] CHAR_B         = 8'h62;
    localparam logic [7:0] CHAR_F         = 8'h66;
    localparam logic [7:0] CHAR_UPPER_A   = 8'h41;
    localparam logic [7:0] CHAR_UPPER_F   = 8'h46;

    localparam logic [7:0] BYTE_NUL       = 8'h00;
    localparam logic [7:0] BYTE_NEWLINE   = 8'h0A;
    localparam logic [7:0] BYTE_TAB       = 8'h09;
    localparam logic [7:0] BYTE_RETURN    = 8'h0D;
    localparam logic [7:0] BYTE_BELL      = 8'h07;
    localparam logic [7:0] BYTE_BACKSPACE = 8'h08;

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_ESCAPE,
        MODE_HEX_FIRST,
        MODE_HEX_SECOND,
        MODE_HEX_SECOND_BAD,
        MODE_DROP
    } t_mode;

    typedef enum logic [2:0] {
        ST_OK,
        ST_UNKNOWN,
        ST_BS_END,
        ST_BAD_HEX,
        ST_HEX_CUT
    } t_status;

    typedef struct packed {
        logic [7:0]           out_byte;
        logic                 has_byte;
        logic                 end_of_literal;
        t_status              status;
        logic [DECODED_W-1:0] decoded_count;
    } t_result;

    // Returns {valid, digit}; valid is 0 when the byte is not a hex digit.
    function automatic logic [4:0] hex_value(input logic [7:0] b);
        logic [4:0] res;
        res = 5'b0;
        if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
            res = {1'b1, b[3:0]};
        end else if ((b >= CHAR_A && b <= CHAR_F) ||
                     (b >= CHAR_UPPER_A && b <= CHAR_UPPER_F)) begin
            res = {1'b1, 4'(b[3:0] + 4'd9)};
        end
        return res;
    endfunction

    // Returns {known, value} for the letter after a backslash.
    function automatic logic [8:0] escape_map(input logic [7:0] b);
        logic [8:0] res;
        res = 9'b0;
        unique case (b)
            CHAR_ZERO:      res = {1'b1, BYTE_NUL};
            CHAR_BACKSLASH: res = {1'b1, CHAR_BACKSLASH};
            CHAR_N:         res = {1'b1, BYTE_NEWLINE};
            CHAR_T:         res = {1'b1, BYTE_TAB};
            CHAR_R:         res = {1'b1, BYTE_RETURN};
            CHAR_A:         res = {1'b1, BYTE_BELL};
            CHAR_B:         res = {1'b1, BYTE_BACKSPACE};
            default:        res = 9'b0;
        endcase
        return res;
    endfunction

endpackage
`default_nettype wire

// File: rtl/sed_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Escape decode stage
// Holds the decode mode, first hex digit and byte count, and works out the
// result of one registered byte combinationally.
// ----------------------------------------------------------------------------
module sed_decode (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_fire,
    input  wire logic [7:0]        i_byte_value,
    input  wire logic              i_is_last,
    input  wire logic              i_is_empty,
    output logic                   o_emit,
    output sed_pkg::t_result       o_result
);

    sed_pkg::t_mode               r_mode, n_mode;
    logic [3:0]                   r_hex, n_hex;
    logic [sed_pkg::CNT_W-1:0]    r_count, n_count;
    logic [sed_pkg::CNT_W-1:0]    sat_count;

    assign sat_count = (r_count < sed_pkg::CNT_W'(sed_pkg::MAX_DECODED_BYTES))
                       ? r_count + 1'b1 : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= sed_pkg::MODE_NORMAL;
            r_hex   <= 4'd0;
            r_count <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_hex   <= n_hex;
            r_count <= n_count;
        end
    end

    always_comb begin
        logic              do_byte;
        logic              do_err;
        logic              err_last;
        logic [7:0]        byte_val;
        sed_pkg::t_status  err_st;
        logic [4:0]        hv;
        logic [8:0]        esc;

        do_byte  = 1'b0;
        do_err   = 1'b0;
        err_last = 1'b1;
        byte_val = 8'd0;
        err_st   = sed_pkg::ST_OK;
        hv       = sed_pkg::hex_value(i_byte_value);
        esc      = sed_pkg::escape_map(i_byte_value);

        n_mode   = r_mode;
        n_hex    = r_hex;
        n_count  = r_count;
        o_emit   = 1'b0;
        o_result = '{out_byte: 8'd0, has_byte: 1'b0, end_of_literal: 1'b0,
                     status: sed_pkg::ST_OK, decoded_count: r_count[sed_pkg::DECODED_W-1:0]};

        if (i_is_empty) begin
            unique case (r_mode)
                sed_pkg::MODE_NORMAL: begin
                    o_emit                  = 1'b1;
                    o_result.end_of_literal = 1'b1;
                    n_count                 = '0;
                end
                sed_pkg::MODE_ESCAPE: begin
                    do_err = 1'b1;
                    err_st = sed_pkg::ST_BS_END;
                end
                sed_pkg::MODE_HEX_FIRST, sed_pkg::MODE_HEX_SECOND,
                sed_pkg::MODE_HEX_SECOND_BAD: begin
                    do_err = 1'b1;
                    err_st = sed_pkg::ST_HEX_CUT;
                end
                default: begin
                    n_mode  = sed_pkg::MODE_NORMAL;
                    n_count = '0;
                end
            endcase
        end else begin
            unique case (r_mode)
                sed_pkg::MODE_NORMAL: begin
                    if (i_byte_value == sed_pkg::CHAR_BACKSLASH) begin
                        if (i_is_last) begin
                            do_err = 1'b1;
                            err_st = sed_pkg::ST_BS_END;
                        end else begin
                            n_mode = sed_pkg::MODE_ESCAPE;
                        end
                    end else begin
                        do_byte  = 1'b1;
                        byte_val = i_byte_value;
                    end
                end
                sed_pkg::MODE_ESCAPE: begin
                    if (esc[8]) begin
                        do_byte  = 1'b1;
                        byte_val = esc[7:0];
                    end else if (i_byte_value == sed_pkg::CHAR_X) begin
                        if (i_is_last) begin
                            do_err = 1'b1;
                            err_st = sed_pkg::ST_HEX_CUT;
                        end else begin
                            n_mode = sed_pkg::MODE_HEX_FIRST;
                        end
                    end else begin
                        do_err   = 1'b1;
                        err_st   = sed_pkg::ST_UNKNOWN;
                        err_last = i_is_last;
                    end
                end
                sed_pkg::MODE_HEX_FIRST: begin
                    if (i_is_last) begin
                        do_err = 1'b1;
                        err_st = sed_pkg::ST_HEX_CUT;
                    end else if (hv[4]) begin
                        n_hex  = hv[3:0];
                        n_mode = sed_pkg::MODE_HEX_SECOND;
                    end else begin
                        n_hex  = 4'd0;
                        n_mode = sed_pkg::MODE_HEX_SECOND_BAD;
                    end
                end
                sed_pkg::MODE_HEX_SECOND: begin
                    if (hv[4]) begin
                        do_byte  = 1'b1;
                        byte_val = {r_hex, hv[3:0]};
                    end else begin
                        do_err   = 1'b1;
                        err_st   = sed_pkg::ST_BAD_HEX;
                        err_last = i_is_last;
                    end
                end
                sed_pkg::MODE_HEX_SECOND_BAD: begin
                    do_err   = 1'b1;
                    err_st   = sed_pkg::ST_BAD_HEX;
                    err_last = i_is_last;
                end
                default: begin
                    if (i_is_last) begin
                        n_mode  = sed_pkg::MODE_NORMAL;
                        n_count = '0;
                    end
                end
            endcase
        end

        if (do_byte) begin
            o_emit                  = 1'b1;
            o_result.out_byte       = byte_val;
            o_result.has_byte       = 1'b1;
            o_result.end_of_literal = i_is_last;
            o_result.decoded_count  = sat_count[sed_pkg::DECODED_W-1:0];
            n_mode                  = sed_pkg::MODE_NORMAL;
            n_count                 = i_is_last ? '0 : sat_count;
        end else if (do_err) begin
            o_emit                  = 1'b1;
            o_result.end_of_literal = 1'b1;
            o_result.status         = err_st;
            n_count                 = '0;
            n_mode                  = err_last ? sed_pkg::MODE_NORMAL : sed_pkg::MODE_DROP;
        end
    end

endmodule
`default_nettype wire

// File: rtl/sed_result_reg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result register
// Holds one decoded result until the receiver takes it.
// ----------------------------------------------------------------------------
module sed_result_reg (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_load,
    input  wire sed_pkg::t_result  i_result,
    input  wire logic              i_stall,
    output logic                   o_ready,
    output logic                   o_valid,
    output sed_pkg::t_result       o_result
);

    logic             r_valid;
    sed_pkg::t_result r_result;

    // The register can take a new result when empty or when it is read this cycle.
    assign o_ready = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule
`default_nettype wire

// File: rtl/string_escape_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// String escape decoder unit
// Decodes backslash escapes in the content bytes of a string literal.
// ----------------------------------------------------------------------------
// Usage: the input channel carries one content byte per transaction with a
// last-byte mark and an empty mark; a transaction is accepted at a clock edge
// where i_in_valid is high and o_in_stall is low. The output channel carries
// zero or one result per input transaction, taken at an edge where
// o_out_valid is high and i_out_stall is low.
// Path: an accepted byte sits in the input register, is decoded and is loaded
// into the result register when that register has room; the receiver takes
// its result from there.
// Throughput: one transaction per cycle while o_in_stall stays low. Bytes
// that open an escape or are dropped after an error produce no result and
// leave without waiting on the output side.
// Stall: while the receiver stalls, a pending result holds in the result
// register and bytes can still be taken into the input register; o_in_stall
// rises while the byte there has a result to load and no room for it.
// Reset: synchronous, active low; both registers empty, decode mode normal,
// byte count zero.
// ----------------------------------------------------------------------------
module string_escape_decoder_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic [7:0]  i_byte_value,
    input  wire logic        i_is_last,
    input  wire logic        i_is_empty,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_has_byte,
    output logic             o_end_of_literal,
    output logic [2:0]       o_status,
    output logic [11:0]      o_decoded_count
);

    // Input register.
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;
    logic             r_in_empty;

    logic             emit;
    logic             out_ready;
    logic             fire;
    sed_pkg::t_result dec_result;
    sed_pkg::t_result out_result;

    // The registered byte moves on when it produces no result, or when the
    // result register has room for the one it produces.
    assign fire       = r_in_valid && (!emit || out_ready);
    assign o_in_stall = r_in_valid && !fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte  <= i_byte_value;
            r_in_last  <= i_is_last;
            r_in_empty <= i_is_empty;
        end
    end

    sed_decode u_decode (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_fire       (fire),
        .i_byte_value (r_in_byte),
        .i_is_last    (r_in_last),
        .i_is_empty   (r_in_empty),
        .o_emit       (emit),
        .o_result     (dec_result)
    );

    sed_result_reg u_result (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (fire && emit),
        .i_result (dec_result),
        .i_stall  (i_out_stall),
        .o_ready  (out_ready),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_out_byte       = out_result.out_byte;
    assign o_has_byte       = out_result.has_byte;
    assign o_end_of_literal = out_result.end_of_literal;
    assign o_status         = out_result.status;
    assign o_decoded_count  = out_result.decoded_count;

endmodule
`default_nettype wire

// File: test/string_escape_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String escape decoder checker
// Watches both channels of the decoder, predicts each result from the
// accepted input transactions and compares the results field by field.
// ----------------------------------------------------------------------------
module string_escape_checker
    import sed_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_stall,
    input  wire logic [7:0]           i_byte_value,
    input  wire logic                 i_is_last,
    input  wire logic                 i_is_empty,
    input  wire logic                 i_out_valid,
    input  wire logic                 i_out_stall,
    input  wire logic [7:0]           i_out_byte,
    input  wire logic                 i_has_byte,
    input  wire logic                 i_end_of_literal,
    input  wire logic [2:0]           i_status,
    input  wire logic [DECODED_W-1:0] i_decoded_count,
    output int                        o_fail_count,
    output int                        o_pending
);

    // Decoder state as the predictor sees it.
    t_mode      dec_mode;
    logic [3:0] hi_nibble;
    int         lit_count;

    t_result    decoded_q[$];
    t_result    predicted;
    t_result    oldest;
    int         mismatches;

    assign o_fail_count = mismatches;

    function automatic bit hex_digit(input logic [7:0] ch, output logic [3:0] nib);
        bit ok;
        ok  = 1'b1;
        nib = 4'd0;
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
            nib = 4'(ch - CHAR_ZERO);
        end else if (ch >= CHAR_A && ch <= CHAR_F) begin
            nib = 4'(ch - CHAR_A + 8'd10);
        end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_F) begin
            nib = 4'(ch - CHAR_UPPER_A + 8'd10);
        end else begin
            ok = 1'b0;
        end
        return ok;
    endfunction

    function automatic void take_byte(input logic [7:0] value, input logic last,
                                      output t_result r);
        if (lit_count < MAX_DECODED_BYTES) begin
            lit_count++;
        end
        r                = '0;
        r.out_byte       = value;
        r.has_byte       = 1'b1;
        r.end_of_literal = last;
        r.status         = ST_OK;
        r.decoded_count  = DECODED_W'(lit_count);
        dec_mode         = MODE_NORMAL;
        if (last) begin
            lit_count = 0;
        end
    endfunction

    // An error closes the literal with the count reached so far.
    function automatic void fail_literal(input t_status st, input logic last,
                                         output t_result r);
        r                = '0;
        r.end_of_literal = 1'b1;
        r.status         = st;
        r.decoded_count  = DECODED_W'(lit_count);
        lit_count        = 0;
        dec_mode         = last ? MODE_NORMAL : MODE_DROP;
    endfunction

    // Advances the predicted state by one byte; returns 1 when a result is due.
    function automatic bit decode_byte(input logic [7:0] ch, input logic last,
                                       input logic empty, output t_result r);
        bit         emitted;
        logic [3:0] nib;
        emitted = 1'b1;
        r       = '0;
        if (empty) begin
            case (dec_mode)
                MODE_NORMAL: begin
                    r.end_of_literal = 1'b1;
                    r.status         = ST_OK;
                    r.decoded_count  = DECODED_W'(lit_count);
                    lit_count        = 0;
                end
                MODE_ESCAPE: begin
                    fail_literal(ST_BS_END, 1'b1, r);
                end
                MODE_HEX_FIRST, MODE_HEX_SECOND, MODE_HEX_SECOND_BAD: begin
                    fail_literal(ST_HEX_CUT, 1'b1, r);
                end
                default: begin
                    dec_mode  = MODE_NORMAL;
                    lit_count = 0;
                    emitted   = 1'b0;
                end
            endcase
        end else begin
            case (dec_mode)
                MODE_NORMAL: begin
                    if (ch != CHAR_BACKSLASH) begin
                        take_byte(ch, last, r);
                    end else if (last) begin
                        fail_literal(ST_BS_END, 1'b1, r);
                    end else begin
                        dec_mode = MODE_ESCAPE;
                        emitted  = 1'b0;
                    end
                end
                MODE_ESCAPE: begin
                    case (ch)
                        CHAR_ZERO:      take_byte(BYTE_NUL, last, r);
                        CHAR_BACKSLASH: take_byte(CHAR_BACKSLASH, last, r);
                        CHAR_N:         take_byte(BYTE_NEWLINE, last, r);
                        CHAR_T:         take_byte(BYTE_TAB, last, r);
                        CHAR_R:         take_byte(BYTE_RETURN, last, r);
                        CHAR_A:         take_byte(BYTE_BELL, last, r);
                        CHAR_B:         take_byte(BYTE_BACKSPACE, last, r);
                        CHAR_X: begin
                            if (last) begin
                                fail_literal(ST_HEX_CUT, 1'b1, r);
                            end else begin
                                dec_mode = MODE_HEX_FIRST;
                                emitted  = 1'b0;
                            end
                        end
                        default:        fail_literal(ST_UNKNOWN, last, r);
                    endcase
                end
                MODE_HEX_FIRST: begin
                    if (last) begin
                        fail_literal(ST_HEX_CUT, 1'b1, r);
                    end else begin
                        if (hex_digit(ch, nib)) begin
                            hi_nibble = nib;
                            dec_mode  = MODE_HEX_SECOND;
                        end else begin
                            hi_nibble = 4'd0;
                            dec_mode  = MODE_HEX_SECOND_BAD;
                        end
                        emitted = 1'b0;
                    end
                end
                MODE_HEX_SECOND: begin
                    if (hex_digit(ch, nib)) begin
                        take_byte({hi_nibble, nib}, last, r);
                    end else begin
                        fail_literal(ST_BAD_HEX, last, r);
                    end
                end
                MODE_HEX_SECOND_BAD: begin
                    fail_literal(ST_BAD_HEX, last, r);
                end
                default: begin
                    if (last) begin
                        dec_mode  = MODE_NORMAL;
                        lit_count = 0;
                    end
                    emitted = 1'b0;
                end
            endcase
        end
        return emitted;
    endfunction

    task automatic check_field(input string field, input logic [11:0] want,
                               input logic [11:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0h, actual %0h", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            dec_mode  = MODE_NORMAL;
            hi_nibble = 4'd0;
            lit_count = 0;
            decoded_q.delete();
        end else begin
            // A result always comes out after its input went in, so the output
            // side is handled first.
            if (i_out_valid && !i_out_stall) begin
                if (decoded_q.size() == 0) begin
                    $error("unexpected result: byte %0h status %0d", i_out_byte, i_status);
                    mismatches++;
                end else begin
                    oldest = decoded_q.pop_front();
                    check_field("out_byte", 12'(oldest.out_byte), 12'(i_out_byte));
                    check_field("has_byte", 12'(oldest.has_byte), 12'(i_has_byte));
                    check_field("end_of_literal", 12'(oldest.end_of_literal),
                                12'(i_end_of_literal));
                    check_field("status", 12'(oldest.status), 12'(i_status));
                    check_field("decoded_count", 12'(oldest.decoded_count),
                                12'(i_decoded_count));
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (decode_byte(i_byte_value, i_is_last, i_is_empty, predicted)) begin
                    decoded_q.push_back(predicted);
                end
            end
        end
        o_pending = decoded_q.size();
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// String escape decoder testbench
// Feeds directed and random string literals through the decoder with random
// idle cycles on both sides; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module testbench;
    import sed_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RANDOM_ITEMS = 1250;
    // Bound for the slowest correct run, which is roughly 1300 items.
    localparam int CYCLE_LIMIT  = 400000;
    // Margin after the last result for a late stray result to show up.
    localparam int TAIL_CYCLES  = 8;
    // Items in the window below run with no idling on either side.
    localparam int BUSY_FROM    = 450;
    localparam int BUSY_TO      = 750;

    // One input transaction as the sender queues it.
    typedef struct {
        logic [7:0] value;
        logic       last;
        logic       empty;
    } t_src_item;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    logic [7:0]           byte_value;
    logic                 is_last;
    logic                 is_empty;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [7:0]           out_byte;
    logic                 has_byte;
    logic                 end_lit;
    logic [2:0]           status;
    logic [DECODED_W-1:0] decoded_count;

    int        fail_count;
    int        pending;
    int        cycle_count = 0;
    int        random_sent;
    bit        in_throttle;
    bit        out_throttle = 1'b1;
    t_src_item lit_q[$];

    initial begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    string_escape_decoder_unit i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_byte_value     (byte_value),
        .i_is_last        (is_last),
        .i_is_empty       (is_empty),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_out_byte       (out_byte),
        .o_has_byte       (has_byte),
        .o_end_of_literal (end_lit),
        .o_status         (status),
        .o_decoded_count  (decoded_count)
    );

    string_escape_checker u_checker (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_byte_value     (byte_value),
        .i_is_last        (is_last),
        .i_is_empty       (is_empty),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_out_byte       (out_byte),
        .i_has_byte       (has_byte),
        .i_end_of_literal (end_lit),
        .i_status         (status),
        .i_decoded_count  (decoded_count),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    // The receiver stalls at random, about 30 percent of the time, while throttled.
    always @(negedge clk) begin
        out_stall <= out_throttle && ($urandom_range(0, 99) < 30);
    end

    // Watchdog: a hung handshake or a result that never arrives ends up here.
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench: errors");
            $finish;
        end
    end

    function automatic void add_item(input logic [7:0] value, input logic last,
                                     input logic empty);
        t_src_item it;
        it.value = value;
        it.last  = last;
        it.empty = empty;
        lit_q.push_back(it);
    endfunction

    // Any byte that does not open an escape.
    function automatic logic [7:0] plain_char();
        logic [7:0] v;
        do begin
            v = 8'($urandom_range(0, 255));
        end while (v == CHAR_BACKSLASH);
        return v;
    endfunction

    // A hex digit in either letter case.
    function automatic logic [7:0] hex_char();
        int d;
        d = $urandom_range(0, 15);
        if (d < 10) begin
            return CHAR_ZERO + 8'(d);
        end
        return ($urandom_range(0, 1) ? CHAR_A : CHAR_UPPER_A) + 8'(d - 10);
    endfunction

    function automatic logic [7:0] non_hex_char();
        logic [7:0] v;
        do begin
            v = 8'($urandom_range(0, 255));
        end while ((v >= CHAR_ZERO && v <= CHAR_NINE) ||
                   (v >= CHAR_A && v <= CHAR_F) ||
                   (v >= CHAR_UPPER_A && v <= CHAR_UPPER_F));
        return v;
    endfunction

    function automatic logic [7:0] escape_letter();
        case ($urandom_range(0, 6))
            0:       return CHAR_ZERO;
            1:       return CHAR_BACKSLASH;
            2:       return CHAR_N;
            3:       return CHAR_T;
            4:       return CHAR_R;
            5:       return CHAR_A;
            default: return CHAR_B;
        endcase
    endfunction

    function automatic logic [7:0] unknown_letter();
        logic [7:0] v;
        do begin
            v = 8'($urandom_range(0, 255));
        end while (v inside {CHAR_ZERO, CHAR_BACKSLASH, CHAR_N, CHAR_T, CHAR_R,
                             CHAR_A, CHAR_B, CHAR_X});
        return v;
    endfunction

    // One well-formed piece of content: a plain byte, an escape or a hex escape.
    function automatic void add_good_piece();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 12) begin
            add_item(plain_char(), 1'b0, 1'b0);
        end else if (pick < 17) begin
            add_item(CHAR_BACKSLASH, 1'b0, 1'b0);
            add_item(escape_letter(), 1'b0, 1'b0);
        end else begin
            add_item(CHAR_BACKSLASH, 1'b0, 1'b0);
            add_item(CHAR_X, 1'b0, 1'b0);
            add_item(hex_char(), 1'b0, 1'b0);
            add_item(hex_char(), 1'b0, 1'b0);
        end
    endfunction

    // Closes the queued literal: usually a last mark on its final byte,
    // sometimes an extra empty mark (with a random byte and last bit).
    function automatic void close_literal();
        if (lit_q.size() == 0 || $urandom_range(0, 9) == 0) begin
            add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end else begin
            lit_q[lit_q.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic void build_good_literal();
        int pieces;
        pieces = $urandom_range(0, 10);
        for (int i = 0; i < pieces; i++) begin
            add_good_piece();
        end
        close_literal();
    endfunction

    // A literal that runs into one of the error cases, then a random tail
    // that the block drops up to the closing mark.
    function automatic void build_broken_literal();
        int pieces;
        int tail;
        pieces = $urandom_range(0, 4);
        tail   = $urandom_range(0, 4);
        for (int i = 0; i < pieces; i++) begin
            add_good_piece();
        end
        add_item(CHAR_BACKSLASH, 1'b0, 1'b0);
        case ($urandom_range(0, 5))
            0: begin
                add_item(unknown_letter(), 1'b0, 1'b0);
            end
            1: begin
                // The bad first digit is only reported at the second one.
                add_item(CHAR_X, 1'b0, 1'b0);
                add_item(non_hex_char(), 1'b0, 1'b0);
                add_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            end
            2: begin
                add_item(CHAR_X, 1'b0, 1'b0);
                add_item(hex_char(), 1'b0, 1'b0);
                add_item(non_hex_char(), 1'b0, 1'b0);
            end
            3: begin
                // Backslash at the end of the literal.
                tail = 0;
            end
            4: begin
                // Hex escape cut off by the last mark on x or the first digit.
                add_item(CHAR_X, 1'b0, 1'b0);
                case ($urandom_range(0, 2))
                    0: add_item(hex_char(), 1'b0, 1'b0);
                    1: add_item(non_hex_char(), 1'b0, 1'b0);
                    default: ;
                endcase
                tail = 0;
            end
            default: begin
                // Empty mark after a backslash, after x or after one or two digits.
                if ($urandom_range(0, 2) != 0) begin
                    add_item(CHAR_X, 1'b0, 1'b0);
                    for (int i = $urandom_range(0, 2); i > 0; i--) begin
                        add_item(($urandom_range(0, 3) != 0) ? hex_char() : non_hex_char(),
                                 1'b0, 1'b0);
                    end
                end
                add_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
                return;
            end
        endcase
        for (int i = 0; i < tail; i++) begin
            add_item(($urandom_range(0, 3) == 0) ? CHAR_BACKSLASH
                                                 : 8'($urandom_range(0, 255)),
                     1'b0, 1'b0);
        end
        close_literal();
    endfunction

    // Noise: unstructured bytes and marks, leaning on the backslash and x.
    function automatic void build_noise();
        logic [7:0] v;
        for (int i = $urandom_range(1, 6); i > 0; i--) begin
            case ($urandom_range(0, 7))
                0:       v = CHAR_BACKSLASH;
                1:       v = CHAR_X;
                2:       v = hex_char();
                default: v = 8'($urandom_range(0, 255));
            endcase
            add_item(v, 1'($urandom_range(0, 3) == 0), 1'($urandom_range(0, 11) == 0));
        end
    endfunction

    // Presents one transaction and holds it until the block takes it. Called
    // and returning just after a falling edge.
    task automatic send_item(input t_src_item it);
        while (in_throttle && $urandom_range(0, 99) < 30) begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid   = 1'b1;
        byte_value = it.value;
        is_last    = it.last;
        is_empty   = it.empty;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        @(negedge clk);
    endtask

    task automatic send_literal();
        foreach (lit_q[i]) begin
            send_item(lit_q[i]);
        end
        lit_q.delete();
    endtask

    // Holds the sender off until every predicted result has come out.
    task automatic wait_for_results();
        in_valid = 1'b0;
        while (pending != 0) begin
            @(negedge clk);
        end
    endtask

    initial begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        byte_value  = 8'h00;
        is_last     = 1'b0;
        is_empty    = 1'b0;
        in_throttle = 1'b1;
        random_sent = 0;
        repeat (4) @(negedge clk);
        rst_n = 1'b1;

        // Directed part. A truly empty literal.
        add_item(8'h00, 1'b0, 1'b1);
        // The extreme byte values pass through unchanged.
        add_item(8'h00, 1'b0, 1'b0);
        add_item(8'hFF, 1'b1, 1'b0);
        // A hex escape with mixed case, then an escape letter as the last byte.
        add_item(CHAR_BACKSLASH, 1'b0, 1'b0);
        add_item(CHAR_X, 1'b0, 1'b0);
        add_item(CHAR_UPPER_A, 1'b0, 1'b0);
        add_item(CHAR_F, 1'b0, 1'b0);
        add_item(CHAR_BACKSLASH, 1'b0, 1'b0);
        add_item(CHAR_ZERO, 1'b1, 1'b0);
        // A backslash as the last byte.
        add_item(CHAR_BACKSLASH, 1'b1, 1'b0);
        // x as the last byte cuts the hex escape off.
        add_item(CHAR_BACKSLASH, 1'b0, 1'b0);
        add_item(CHAR_X, 1'b1, 1'b0);
        // A first digit as the last byte is cut off even when it is not hex.
        add_item(CHAR_BACKSLASH, 1'b0, 1'b0);
        add_item(CHAR_X, 1'b0, 1'b0);
        add_item(8'h7A, 1'b1, 1'b0);
        // A bad first digit, reported at the second; the drop that follows is
        // ended by an empty mark that also carries a last mark.
        add_item(CHAR_BACKSLASH, 1'b0, 1'b0);
        add_item(CHAR_X, 1'b0, 1'b0);
        add_item(8'h67, 1'b0, 1'b0);
        add_item(8'h31, 1'b0, 1'b0);
        add_item(8'hA7, 1'b1, 1'b1);
        // An unknown escape, with a byte dropped through the last mark.
        add_item(CHAR_BACKSLASH, 1'b0, 1'b0);
        add_item(8'h71, 1'b0, 1'b0);
        add_item(8'h35, 1'b1, 1'b0);
        // An empty mark right after a backslash.
        add_item(CHAR_BACKSLASH, 1'b0, 1'b0);
        add_item(8'h00, 1'b0, 1'b1);
        send_literal();
        wait_for_results();

        // Random part: mostly well-formed literals with random content.
        while (random_sent < RANDOM_ITEMS) begin
            in_throttle  = !(random_sent >= BUSY_FROM && random_sent < BUSY_TO);
            out_throttle = in_throttle;
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5, 6: build_good_literal();
                7:                   build_broken_literal();
                default:             build_noise();
            endcase
            random_sent += lit_q.size();
            send_literal();
        end

        in_throttle  = 1'b1;
        out_throttle = 1'b1;
        wait_for_results();
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0) begin
            $display("testbench: clean");
        end else begin
            $display("testbench: errors");
        end
        $finish;
    end

endmodule

// File: string_escape_decoder_unit.f
rtl/sed_pkg.sv
rtl/sed_decode.sv
rtl/sed_result_reg.sv
rtl/string_escape_decoder_unit.sv
test/string_escape_checker.sv
test/testbench.sv
